### hdl/hcmb_pkg.sv
// ----------------------------------------------------------------------------
// hcmb_pkg
// types, target codes and the address decoder shared by the memory bus blocks
// ----------------------------------------------------------------------------
`default_nettype none

package hcmb_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LDROM = 2'd2;
    localparam logic [1:0] MODE_LDBOOT = 2'd3;

    typedef logic [3:0] t_tgt;

    localparam t_tgt T_NONE = 4'd0;
    localparam t_tgt T_CROM = 4'd1;
    localparam t_tgt T_BOOT = 4'd2;
    localparam t_tgt T_VRAM = 4'd3;
    localparam t_tgt T_CRAM = 4'd4;
    localparam t_tgt T_WRAM = 4'd5;
    localparam t_tgt T_OAM  = 4'd6;
    localparam t_tgt T_HRAM = 4'd7;
    localparam t_tgt T_LY   = 4'd8;
    localparam t_tgt T_IO   = 4'd9;
    localparam t_tgt T_DMA  = 4'd10;

    localparam int ROM_AW    = 15;
    localparam int BOOT_AW   = 8;
    localparam int RAM_AW    = 13;
    localparam int OAM_AW    = 8;
    localparam int HRAM_AW   = 7;
    localparam int ROM_BYTES = 32768;
    localparam int BOOT_BYTES = 256;
    localparam int RAM_BYTES = 8192;
    localparam int OAM_BYTES = 160;
    localparam int HRAM_BYTES = 127;
    localparam int IO_COUNT  = 15;
    localparam int IO_JOYP   = 0;

    localparam logic [15:0] ADDR_LY  = 16'hFF44;
    localparam logic [15:0] ADDR_DMA = 16'hFF46;

    localparam logic [15:0] IO_ADDR [IO_COUNT] = '{
        16'hFF00, 16'hFF01, 16'hFF02, 16'hFF0F, 16'hFF40, 16'hFF41, 16'hFF42,
        16'hFF43, 16'hFF45, 16'hFF47, 16'hFF48, 16'hFF49, 16'hFF4A, 16'hFF4B,
        16'hFFFF
    };

    typedef struct packed {
        t_tgt        tgt;
        logic [14:0] idx;
        logic [3:0]  slot;
    } t_dec;

    typedef struct packed {
        logic       wr;
        t_dec       dec;
        logic [7:0] data;
        logic [7:0] line;
    } t_cmd;

    function automatic t_dec bus_decode(input logic [15:0] a, input logic boot);
        t_dec d;
        logic hit;
        d.tgt  = T_NONE;
        d.idx  = a[14:0];
        d.slot = 4'd0;
        hit    = 1'b0;
        for (int k = 0; k < IO_COUNT; k++) begin
            if (IO_ADDR[k] == a) begin
                d.slot = 4'(k);
                hit    = 1'b1;
            end
        end
        if (a < 16'h8000) begin
            d.tgt = (boot && a < 16'h0100) ? T_BOOT : T_CROM;
        end else if (a < 16'hA000) begin
            d.tgt = T_VRAM;
        end else if (a < 16'hC000) begin
            d.tgt = T_CRAM;
        end else if (a < 16'hFE00) begin
            d.tgt = T_WRAM;
        end else if (a < 16'hFEA0) begin
            d.tgt = T_OAM;
        end else if (a >= 16'hFF80 && a < 16'hFFFF) begin
            d.tgt = T_HRAM;
        end else if (a == ADDR_LY) begin
            d.tgt = T_LY;
        end else if (hit) begin
            d.tgt = T_IO;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/hcmb_if.sv
// ----------------------------------------------------------------------------
// hcmb_in_if / hcmb_out_if
// valid/ready channels for bus accesses and their read data
// ----------------------------------------------------------------------------
`default_nettype none

interface hcmb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        in_boot;
    logic [7:0]  scan_line;
    modport source (output valid, mode, address, write_data, in_boot, scan_line,
                    input ready);
    modport sink (input valid, mode, address, write_data, in_boot, scan_line,
                  output ready);
endinterface

interface hcmb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

### hdl/handheld_console_memory_bus.sv
// ----------------------------------------------------------------------------
// handheld_console_memory_bus
// handheld console memory map decoder with sprite table copy
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  i_in      in    mode, address, write_data, in_boot, scan_line
//  o_out     out   read_data
//
//  after reset the rams other than crom and boot are swept one entry per
//  cycle with i_in.ready low; reset is synchronous and active low
//  writes, loads: idle, out; reads: idle, read (registered ram read), out
//  a write to ff46 copies 160 bytes, one byte per cycle
//  a queue of QUEUE_DEPTH items accepts until full while o_out stalls
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_console_memory_bus
    import hcmb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hcmb_in_if.sink    i_in,
    hcmb_out_if.source o_out
);
    t_cmd                             cmd;
    logic                             cmd_valid;
    logic                             pop;
    logic                             busy;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] count;

    hcmb_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_busy(busy),
        .i_pop(pop), .o_cmd(cmd), .o_cmd_valid(cmd_valid), .o_count(count));

    hcmb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_pop(pop), .o_busy(busy), .o_out(o_out));

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_out.valid) else $error("result during ram sweep");
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_in.ready) else $error("item accepted during ram sweep");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) else $error("queue overflow");
    a_pop_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid && !o_out.valid) else $error("pop while busy");
endmodule

`default_nettype wire

### hdl/hcmb_ram.sv
// ----------------------------------------------------------------------------
// hcmb_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hcmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

### hdl/hcmb_front.sv
// ----------------------------------------------------------------------------
// hcmb_front
// accepts bus accesses, decodes the target and queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module hcmb_front
    import hcmb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    hcmb_in_if.sink                          i_in,
    input  wire                              i_busy,
    input  wire                              i_pop,
    output t_cmd                             o_cmd,
    output logic                             o_cmd_valid,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;
    t_cmd            cmd_in;
    t_dec            d;
    logic            push;
    logic            pop;

    always_comb begin
        cmd_in.data = i_in.write_data;
        cmd_in.line = i_in.scan_line;
        cmd_in.wr   = (i_in.mode != MODE_READ);
        d           = bus_decode(i_in.address, 1'b0);
        case (i_in.mode)
            MODE_READ: begin
                d = bus_decode(i_in.address, i_in.in_boot);
            end
            MODE_WRITE: begin
                if (i_in.address == ADDR_DMA) begin
                    d.tgt = T_DMA;
                end else if (d.tgt == T_CROM || d.tgt == T_BOOT || d.tgt == T_LY) begin
                    d.tgt = T_NONE;
                end
            end
            MODE_LDROM: begin
                d.tgt = T_CROM;
                d.idx = i_in.address[14:0];
            end
            default: begin
                d.tgt = T_BOOT;
                d.idx = {7'd0, i_in.address[7:0]};
            end
        endcase
        cmd_in.dec = d;
    end

    assign i_in.ready  = (r_count != CW'(QUEUE_DEPTH)) && !i_busy;
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end
endmodule

`default_nettype wire

### hdl/hcmb_back.sv
// ----------------------------------------------------------------------------
// hcmb_back
// carries out queued commands on the memories, io registers and sprite copy
// ----------------------------------------------------------------------------
`default_nettype none

module hcmb_back
    import hcmb_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    input  wire          i_cmd_valid,
    output logic         o_pop,
    output logic         o_busy,
    hcmb_out_if.source   o_out
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DMA   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [RAM_AW-1:0]   r_cnt, n_cnt;
    logic [7:0]          r_n, n_n;
    logic [7:0]          r_page, n_page;
    t_tgt                r_tgt, n_tgt;
    logic [3:0]          r_slot, n_slot;
    logic [7:0]          r_line, n_line;
    logic [7:0]          r_out, n_out;
    logic [7:0]          r_io [IO_COUNT];

    t_dec                dd, rd;
    logic [7:0]          sel;
    logic [7:0]          d_crom, d_boot, d_vram, d_cram, d_wram, d_oam, d_hram;
    logic                we_crom, we_boot, we_vram, we_cram, we_wram, we_oam, we_hram;
    logic                we_io;
    logic [RAM_AW-1:0]   wa_ram;
    logic [OAM_AW-1:0]   wa_oam;
    logic [HRAM_AW-1:0]  wa_hram;
    logic [7:0]          wd_ram, wd_oam;

    assign dd = bus_decode({r_page, r_n}, 1'b0);
    assign rd = (r_state == ST_DMA) ? dd : i_cmd.dec;

    always_comb begin
        case (r_tgt)
            T_CROM:  sel = d_crom;
            T_BOOT:  sel = d_boot;
            T_VRAM:  sel = d_vram;
            T_CRAM:  sel = d_cram;
            T_WRAM:  sel = d_wram;
            T_OAM:   sel = d_oam;
            T_HRAM:  sel = d_hram;
            T_LY:    sel = r_line;
            T_IO:    sel = r_io[r_slot];
            default: sel = 8'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_page  = r_page;
        n_tgt   = r_tgt;
        n_slot  = r_slot;
        n_line  = r_line;
        n_out   = r_out;
        o_pop   = 1'b0;
        we_crom = 1'b0;
        we_boot = 1'b0;
        we_vram = 1'b0;
        we_cram = 1'b0;
        we_wram = 1'b0;
        we_oam  = 1'b0;
        we_hram = 1'b0;
        we_io   = 1'b0;
        wa_ram  = i_cmd.dec.idx[RAM_AW-1:0];
        wa_oam  = i_cmd.dec.idx[OAM_AW-1:0];
        wa_hram = i_cmd.dec.idx[HRAM_AW-1:0];
        wd_ram  = i_cmd.data;
        wd_oam  = i_cmd.data;
        case (r_state)
            ST_CLEAR: begin
                // one entry of vram, cram and wram per cycle, of oam and hram while in range
                we_vram = 1'b1;
                we_cram = 1'b1;
                we_wram = 1'b1;
                we_oam  = (r_cnt < RAM_AW'(OAM_BYTES));
                we_hram = (r_cnt < RAM_AW'(HRAM_BYTES));
                wa_ram  = r_cnt;
                wa_oam  = r_cnt[OAM_AW-1:0];
                wa_hram = r_cnt[HRAM_AW-1:0];
                wd_ram  = 8'hFF;
                wd_oam  = 8'd0;
                n_cnt   = r_cnt + RAM_AW'(1);
                if (r_cnt == RAM_AW'(RAM_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop  = 1'b1;
                    n_tgt  = i_cmd.dec.tgt;
                    n_slot = i_cmd.dec.slot;
                    n_line = i_cmd.line;
                    n_out  = 8'd0;
                    if (!i_cmd.wr) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_OUT;
                        case (i_cmd.dec.tgt)
                            T_CROM: we_crom = 1'b1;
                            T_BOOT: we_boot = 1'b1;
                            T_VRAM: we_vram = 1'b1;
                            T_CRAM: we_cram = 1'b1;
                            T_WRAM: we_wram = 1'b1;
                            T_OAM:  we_oam  = 1'b1;
                            T_HRAM: we_hram = 1'b1;
                            T_IO:   we_io   = 1'b1;
                            T_DMA: begin
                                n_state = ST_DMA;
                                n_n     = 8'd0;
                                n_page  = i_cmd.data;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_READ: begin
                n_out   = sel;
                n_state = ST_OUT;
            end
            ST_DMA: begin
                // read byte n while writing byte n-1 fetched last cycle
                if (r_n != 8'd0) begin
                    we_oam = 1'b1;
                    wa_oam = r_n - 8'd1;
                    wd_oam = sel;
                end
                if (r_n == 8'(OAM_BYTES)) begin
                    n_out   = 8'd0;
                    n_state = ST_OUT;
                end else begin
                    n_tgt  = dd.tgt;
                    n_slot = dd.slot;
                    n_n    = r_n + 8'd1;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_n     <= '0;
            for (int k = 0; k < IO_COUNT; k++) begin
                r_io[k] <= (k == IO_JOYP) ? 8'hFF : 8'h00;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            if (we_io) begin
                r_io[i_cmd.dec.slot] <= i_cmd.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_tgt  <= n_tgt;
        r_slot <= n_slot;
        r_line <= n_line;
        r_out  <= n_out;
    end

    assign o_busy          = (r_state == ST_CLEAR);
    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.read_data = r_out;

    hcmb_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_crom (
        .i_clk(i_clk), .i_we(we_crom), .i_waddr(i_cmd.dec.idx[ROM_AW-1:0]),
        .i_wdata(i_cmd.data), .i_raddr(rd.idx[ROM_AW-1:0]), .o_rdata(d_crom));
    hcmb_ram #(.WIDTH(8), .DEPTH(BOOT_BYTES)) u_boot (
        .i_clk(i_clk), .i_we(we_boot), .i_waddr(i_cmd.dec.idx[BOOT_AW-1:0]),
        .i_wdata(i_cmd.data), .i_raddr(rd.idx[BOOT_AW-1:0]), .o_rdata(d_boot));
    hcmb_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(we_vram), .i_waddr(wa_ram),
        .i_wdata(wd_ram), .i_raddr(rd.idx[RAM_AW-1:0]), .o_rdata(d_vram));
    hcmb_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_cram (
        .i_clk(i_clk), .i_we(we_cram), .i_waddr(wa_ram),
        .i_wdata(o_busy ? 8'd0 : wd_ram), .i_raddr(rd.idx[RAM_AW-1:0]),
        .o_rdata(d_cram));
    hcmb_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_wram (
        .i_clk(i_clk), .i_we(we_wram), .i_waddr(wa_ram),
        .i_wdata(wd_ram), .i_raddr(rd.idx[RAM_AW-1:0]), .o_rdata(d_wram));
    hcmb_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam (
        .i_clk(i_clk), .i_we(we_oam), .i_waddr(wa_oam),
        .i_wdata(wd_oam), .i_raddr(rd.idx[OAM_AW-1:0]), .o_rdata(d_oam));
    hcmb_ram #(.WIDTH(8), .DEPTH(HRAM_BYTES)) u_hram (
        .i_clk(i_clk), .i_we(we_hram), .i_waddr(wa_hram),
        .i_wdata(o_busy ? 8'd0 : wd_ram), .i_raddr(rd.idx[HRAM_AW-1:0]),
        .o_rdata(d_hram));
endmodule

`default_nettype wire
